[hdl/acbc_pkg.sv]
// Shared types, constants and AES round functions for the CBC encrypt core
package acbc_pkg;

   localparam int ACBC_QUEUE_DEPTH = 2;
   localparam int ACBC_ROUNDS      = 10;
   localparam int ACBC_RND_W       = 4;

   typedef enum logic [1:0] {
      CSR_KEY_HIGH = 2'd0,
      CSR_KEY_LOW  = 2'd1,
      CSR_IV_HIGH  = 2'd2,
      CSR_IV_LOW   = 2'd3
   } csr_index_type;

   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_ROUND = 1'b1
   } eng_state_type;

   typedef struct packed {
      logic         restart;
      logic [127:0] block;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] rcon(input logic [ACBC_RND_W-1:0] rnd);
      logic [7:0] r;
      case (rnd)
         4'd1:    r = 8'h01;
         4'd2:    r = 8'h02;
         4'd3:    r = 8'h04;
         4'd4:    r = 8'h08;
         4'd5:    r = 8'h10;
         4'd6:    r = 8'h20;
         4'd7:    r = 8'h40;
         4'd8:    r = 8'h80;
         4'd9:    r = 8'h1b;
         4'd10:   r = 8'h36;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // next round key from the previous one; byte 0 in bits 127:120
   function automatic logic [127:0] next_key(input logic [127:0] k,
                                             input logic [7:0]   rc);
      logic [31:0] t, w0, w1, w2, w3;
      t  = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
      w0 = k[127:96] ^ t;
      w1 = k[95:64] ^ w0;
      w2 = k[63:32] ^ w1;
      w3 = k[31:0] ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   // SubBytes, ShiftRows and (unless last) MixColumns
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
      logic [7:0]   b [16];
      logic [7:0]   t [16];
      logic [7:0]   a0, a1, a2, a3, al;
      logic [127:0] r;
      for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
      for (int c = 0; c < 4; c++)
         for (int rw = 0; rw < 4; rw++)
            t[rw+4*c] = SBOX[b[rw + 4*((c+rw) & 3)]];
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c];
            a1 = t[4*c+1];
            a2 = t[4*c+2];
            a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
            t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
            t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
            t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) r[127-8*i -: 8] = t[i];
      return r;
   endfunction

endpackage

[hdl/acbc_ifs.sv]
// Request and response channel interfaces
interface acbc_req_if;
   logic        valid;
   logic        ready;
   logic        restart;
   logic [63:0] block_high;
   logic [63:0] block_low;
   modport source (output valid, restart, block_high, block_low, input ready);
   modport sink   (input valid, restart, block_high, block_low, output ready);
endinterface

interface acbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] cipher_high;
   logic [63:0] cipher_low;
   modport source (output valid, cipher_high, cipher_low, input ready);
   modport sink   (input valid, cipher_high, cipher_low, output ready);
endinterface

[hdl/acbc_front.sv]
// Front end: accepts request transactions into a small queue
module acbc_front
   import acbc_pkg::*;
#(
   parameter int QUEUE_DEPTH = ACBC_QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   acbc_req_if.sink      req,
   output queue_out_type head,
   input  logic          pop
);
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   item_type         q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, do_pop;

   assign req.ready = (count_ff != FULL_CNT);
   assign push      = req.valid && req.ready;
   assign do_pop    = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.item  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop) rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !do_pop) count_in = count_ff + 1'b1;
      else if (!push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= '{restart: req.restart, block: {req.block_high, req.block_low}};
      end
   end
endmodule

[hdl/acbc_engine.sv]
// Back end: iterative AES-128 rounds with CBC chaining and output register
module acbc_engine
   import acbc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic [127:0]  key,
   input  logic [127:0]  iv,
   input  queue_out_type head,
   output logic          pop,
   acbc_rsp_if.source    rsp
);
   eng_state_type         state_ff, state_in;
   logic [ACBC_RND_W-1:0] rnd_ff;
   logic [127:0]          st_ff, rk_ff, chain_ff, out_ff;
   logic                  out_valid_ff;
   logic [127:0]          nrk, rnd_out, chain_sel;
   logic                  start, finish, last;

   assign last      = (rnd_ff == ACBC_RND_W'(ACBC_ROUNDS));
   assign nrk       = next_key(rk_ff, rcon(rnd_ff));
   assign rnd_out   = aes_round(st_ff, last) ^ nrk;
   assign chain_sel = head.item.restart ? iv : chain_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (head.valid) state_in = ST_ROUND;
         ST_ROUND: if (finish) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      start  = 1'b0;
      finish = 1'b0;
      unique case (state_ff)
         ST_IDLE:  start = head.valid;
         ST_ROUND: finish = last && (!out_valid_ff || rsp.ready);
         default:  ;
      endcase
   end

   assign pop             = start;
   assign rsp.valid       = out_valid_ff;
   assign rsp.cipher_high = out_ff[127:64];
   assign rsp.cipher_low  = out_ff[63:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         chain_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (finish) begin
            out_valid_ff <= 1'b1;
            chain_ff     <= rnd_out;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         st_ff  <= head.item.block ^ chain_sel ^ key;
         rk_ff  <= key;
         rnd_ff <= ACBC_RND_W'(1);
      end else if (state_ff == ST_ROUND && !last) begin
         st_ff  <= rnd_out;
         rk_ff  <= nrk;
         rnd_ff <= rnd_ff + 1'b1;
      end
      if (finish) out_ff <= rnd_out;
   end
endmodule

[hdl/aes128_cbc_encrypt_core.sv]
// AES-128 CBC encrypt core: top level with configuration registers
// Block throughput is set by the chained round loop (one AES round per cycle,
//   the last round held while the response register is full, and the next
//   block needs this block's ciphertext).
// Requests queue up while the engine works; the response register frees the engine.
// Reset (synchronous, active high) clears key, IV, chain, queue and response.
module aes128_cbc_encrypt_core
   import acbc_pkg::*;
#(
   parameter int QUEUE_DEPTH = ACBC_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   acbc_req_if.sink    req,
   acbc_rsp_if.source  rsp
);
   logic [63:0]   key_high_ff, key_low_ff, iv_high_ff, iv_low_ff;
   queue_out_type head;
   logic          pop;

   // configuration registers; to be written only while idle (the user's duty, not enforced here)
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         iv_high_ff  <= '0;
         iv_low_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY_HIGH: key_high_ff <= csr_wdata;
            CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            CSR_IV_HIGH:  iv_high_ff  <= csr_wdata;
            CSR_IV_LOW:   iv_low_ff   <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // front: request queue
   acbc_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .head  (head),
      .pop   (pop)
   );

   // back: round engine, chain value and response register
   acbc_engine u_engine (
      .clock (clock),
      .reset (reset),
      .key   ({key_high_ff, key_low_ff}),
      .iv    ({iv_high_ff, iv_low_ff}),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp)
   );
endmodule
